[rtl/hgna_pkg.sv]
// ----------------------------------------------------------------------------
// hgna_pkg: shared types and constants for the heat grid stencil
// Widths, size limits, request structs and the reciprocal used for /3.
// ----------------------------------------------------------------------------
package hgna_pkg;

    // field widths
    localparam int TEMP_W = 16;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 11;

    // grid limits
    localparam int MAX_ROWS   = 1024;
    localparam int MAX_COLS   = 1024;
    localparam int MAX_SIZE   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SIZE_W     = $clog2(MAX_SIZE + 1);
    localparam int ADDR_W     = $clog2(MAX_COLS);
    localparam int GRID_RESET = 100;

    // neighbor sum and divide by three through a reciprocal
    localparam int SUM_W       = TEMP_W + 2;
    localparam int DIV3_SHIFT  = SUM_W + 1;
    localparam int DIV3_MULT_W = SUM_W;
    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT =
        DIV3_MULT_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
    localparam int PROD_W      = SUM_W + DIV3_MULT_W;

    // result stream packing
    localparam int OUT_FIELDS_W = 2 * POS_W + TEMP_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } cfg_reg_t;

    // neighbor count of a result
    typedef enum logic [1:0] {
        DIV_BY2,
        DIV_BY3,
        DIV_BY4
    } div_t;

    // classified input sample
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              row_ge1;
        logic              row_ge2;
        logic              col_ge1;
        logic              col_ge2;
        logic              last_col;
        logic              last_row;
    } item_t;

    // result waiting for its division
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        div_t             div;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } result_t;

    // grid size in use, held to 2..limit
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] value,
                                                     input logic [SIZE_W-1:0] limit);
        logic [SIZE_W-1:0] size;
        if (value < CFG_W'(2)) begin
            size = SIZE_W'(2);
        end
        else if (value > limit) begin
            size = limit;
        end
        else begin
            size = SIZE_W'(value);
        end
        return size;
    endfunction

endpackage

[rtl/heat_grid_neighbor_average.sv]
// ----------------------------------------------------------------------------
// heat_grid_neighbor_average: one Jacobi sweep of a four-neighbor heat grid
//
//   channel  direction  contents
//   cfg      in         cfg_index selects grid_rows or grid_cols, cfg_data value
//   s_axis   in         one cell temperature per request, raster order
//   m_axis   out        new value of one cell with its row and column
//
// One temperature is taken per cycle while the queue has room; each row from
// the second on gives one result per sample, trailing the input by one row.
// In the last row a sample past the first column gives two results (three on
// the last column); the result slots drain one per cycle while the divider is
// ready, and the next sample waits until they have drained.
// A result passes through registers in this order: the queue is written when
// its sample is accepted, then the result slots, the divider input and the
// output register follow; a stall can hold it between any two of them.
// Reset clears positions, queue, slot valid bits and output valid; the row
// banks are not cleared. A size write restarts the sweep at cell (0,0).
// An output stall holds the back end; the four-entry queue keeps taking input
// until it fills.
// ----------------------------------------------------------------------------
module heat_grid_neighbor_average import hgna_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    // configuration write
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TEMP_W-1:0] s_tdata,   // [15:0] temperature
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [9:0] cell_row, [19:10] cell_col,
                                         // [35:20] average, [39:36] zero
    output logic              m_tlast    // sweep_done
);

    logic    q_full;
    logic    q_push;
    item_t   q_item;
    logic    q_pop;
    logic    q_empty;
    item_t   q_head;
    logic    res_valid;
    result_t res_data;
    logic    res_ready;

    // intake and classification
    hgna_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    // decoupling queue
    hgna_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // line stores and sums
    hgna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready)
    );

    // division and output register
    hgna_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[rtl/hgna_front.sv]
// ----------------------------------------------------------------------------
// hgna_front: sample intake and classification
// Holds the grid size, tracks the raster position and tags every sample with
// its position and edge flags before it enters the queue.
// ----------------------------------------------------------------------------
module hgna_front import hgna_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TEMP_W-1:0] s_tdata,
    input  logic              q_full,
    output logic              q_push,
    output item_t             q_item
);

    logic [CFG_W-1:0]  grid_rows_reg;
    logic [CFG_W-1:0]  grid_cols_reg;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  row_next;
    logic [POS_W-1:0]  col_reg;
    logic [POS_W-1:0]  col_next;
    logic [SIZE_W-1:0] rows_use;
    logic [SIZE_W-1:0] cols_use;
    logic              last_col;
    logic              last_row;
    logic              accept;

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= CFG_W'(GRID_RESET);
            grid_cols_reg <= CFG_W'(GRID_RESET);
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_GRID_ROWS)
            begin
                grid_rows_reg <= cfg_data;
            end
            else
            begin
                grid_cols_reg <= cfg_data;
            end
        end
    end

    // size in use and edge detection
    assign rows_use = clamp_size(grid_rows_reg, SIZE_W'(MAX_ROWS));
    assign cols_use = clamp_size(grid_cols_reg, SIZE_W'(MAX_COLS));
    assign last_col = (SIZE_W'(col_reg) == (cols_use - SIZE_W'(1)));
    assign last_row = (SIZE_W'(row_reg) == (rows_use - SIZE_W'(1)));

    // handshake into the queue
    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    // raster position, restarted by any size write
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_wr_en)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // tagged sample
    always_comb
    begin
        q_item.temp     = s_tdata;
        q_item.row      = row_reg;
        q_item.col      = col_reg;
        q_item.row_ge1  = (row_reg != '0);
        q_item.row_ge2  = (row_reg > POS_W'(1));
        q_item.col_ge1  = (col_reg != '0);
        q_item.col_ge2  = (col_reg > POS_W'(1));
        q_item.last_col = last_col;
        q_item.last_row = last_row;
    end

endmodule

[rtl/hgna_queue.sv]
// ----------------------------------------------------------------------------
// hgna_queue: short queue of tagged samples
// Lets the intake keep taking samples while the back end is held.
// ----------------------------------------------------------------------------
module hgna_queue import hgna_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/hgna_back.sv]
// ----------------------------------------------------------------------------
// hgna_back: line stores, neighbor window and result sums
// Two row banks hold the rows by parity. Each taken sample writes its bank
// and prefetches what the next position needs. Up to three sums per sample
// wait in slots and leave one per cycle toward the divider while it is ready.
// ----------------------------------------------------------------------------
module hgna_back import hgna_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  item_t   q_head,
    output logic    q_pop,
    output logic    res_valid,
    output result_t res_data,
    input  logic    res_ready
);

    // row banks
    logic [TEMP_W-1:0] bank0_mem [MAX_COLS];
    logic [TEMP_W-1:0] bank1_mem [MAX_COLS];
    logic [TEMP_W-1:0] rd_bank0_reg;
    logic [TEMP_W-1:0] rd_bank1_reg;
    logic [ADDR_W-1:0] rd_addr0;
    logic [ADDR_W-1:0] rd_addr1;
    logic [ADDR_W-1:0] wr_addr;

    // window registers
    logic [TEMP_W-1:0] first0_reg;
    logic [TEMP_W-1:0] first1_reg;
    logic [TEMP_W-1:0] rcur_reg;
    logic [TEMP_W-1:0] prev_reg;
    logic [TEMP_W-1:0] x1_reg;
    logic [TEMP_W-1:0] x2_reg;

    // pending results
    result_t    pend_slot_reg [3];
    logic [2:0] pend_valid_reg;
    logic [2:0] pend_valid_next;
    logic [2:0] pop_mask;
    result_t    pop_slot;
    logic       pop;
    logic       take;
    logic       res_valid_reg;
    result_t    res_data_reg;

    // current sample and its neighbors
    logic [TEMP_W-1:0] x;
    logic [TEMP_W-1:0] up_up;
    logic [TEMP_W-1:0] up_right;
    logic [TEMP_W-1:0] up_here;
    logic [POS_W-1:0]  next_col;
    logic              next_par;
    logic [2:0]        cnt_a;
    result_t           slot_a;
    result_t           slot_b;
    result_t           slot_c;
    logic [2:0]        new_mask;

    // take a sample once the slots drain this cycle
    assign pop  = res_ready && (pend_valid_reg != 3'b000);
    assign take = !q_empty && ((pend_valid_reg == 3'b000) ||
                  (res_ready && ((pend_valid_reg & (pend_valid_reg - 3'd1)) == 3'b000)));
    assign q_pop = take;

    // neighbor values for this position
    assign x        = q_head.temp;
    assign up_up    = q_head.row[0] ? rd_bank1_reg : rd_bank0_reg;
    assign up_right = q_head.col_ge1 ? (q_head.row[0] ? rd_bank0_reg : rd_bank1_reg)
                                     : first1_reg;
    assign up_here  = q_head.col_ge1 ? rcur_reg : first0_reg;

    // next position: older value from its own bank, right value from the other
    assign next_col = q_head.last_col ? '0 : q_head.col + POS_W'(1);
    assign next_par = q_head.last_col ? (q_head.last_row ? 1'b0 : ~q_head.row[0])
                                      : q_head.row[0];
    assign rd_addr0 = next_par ? ADDR_W'(next_col) + ADDR_W'(1) : ADDR_W'(next_col);
    assign rd_addr1 = next_par ? ADDR_W'(next_col) : ADDR_W'(next_col) + ADDR_W'(1);
    assign wr_addr  = ADDR_W'(q_head.col);

    // bank 0
    always_ff @(posedge clk)
    begin
        if (take && !q_head.row[0])
        begin
            bank0_mem[wr_addr] <= x;
        end
        if (take)
        begin
            rd_bank0_reg <= bank0_mem[rd_addr0];
        end
    end

    // bank 1
    always_ff @(posedge clk)
    begin
        if (take && q_head.row[0])
        begin
            bank1_mem[wr_addr] <= x;
        end
        if (take)
        begin
            rd_bank1_reg <= bank1_mem[rd_addr1];
        end
    end

    // sliding window along the row
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rcur_reg <= up_right;
            prev_reg <= up_here;
            x1_reg   <= x;
            x2_reg   <= x1_reg;
            if (!q_head.col_ge1)
            begin
                first0_reg <= x;
            end
            if (q_head.col_ge1 && !q_head.col_ge2)
            begin
                first1_reg <= x;
            end
        end
    end

    // cell above the sample
    assign cnt_a = 3'd1 + 3'(q_head.row_ge2) + 3'(q_head.col_ge1) + 3'(!q_head.last_col);

    always_comb
    begin
        slot_a.sum = SUM_W'(x)
                   + (q_head.row_ge2  ? SUM_W'(up_up)    : SUM_W'(0))
                   + (q_head.col_ge1  ? SUM_W'(prev_reg) : SUM_W'(0))
                   + (!q_head.last_col ? SUM_W'(up_right) : SUM_W'(0));
        case (cnt_a)
            3'd3:    slot_a.div = DIV_BY3;
            3'd4:    slot_a.div = DIV_BY4;
            default: slot_a.div = DIV_BY2;
        endcase
        slot_a.row  = q_head.row - POS_W'(1);
        slot_a.col  = q_head.col;
        slot_a.done = 1'b0;
    end

    // last row: cell left of the sample
    always_comb
    begin
        slot_b.sum  = SUM_W'(x) + SUM_W'(prev_reg)
                    + (q_head.col_ge2 ? SUM_W'(x2_reg) : SUM_W'(0));
        slot_b.div  = q_head.col_ge2 ? DIV_BY3 : DIV_BY2;
        slot_b.row  = q_head.row;
        slot_b.col  = q_head.col - POS_W'(1);
        slot_b.done = 1'b0;
    end

    // last row: corner cell closes the sweep
    always_comb
    begin
        slot_c.sum  = SUM_W'(up_here) + SUM_W'(x1_reg);
        slot_c.div  = DIV_BY2;
        slot_c.row  = q_head.row;
        slot_c.col  = q_head.col;
        slot_c.done = 1'b1;
    end

    assign new_mask = {q_head.last_row && q_head.last_col,
                       q_head.last_row && q_head.col_ge1,
                       q_head.row_ge1};

    // oldest pending result first
    always_comb
    begin
        pop_mask = 3'b000;
        pop_slot = pend_slot_reg[0];
        if (pend_valid_reg[0])
        begin
            pop_mask = 3'b001;
        end
        else if (pend_valid_reg[1])
        begin
            pop_mask = 3'b010;
            pop_slot = pend_slot_reg[1];
        end
        else if (pend_valid_reg[2])
        begin
            pop_mask = 3'b100;
            pop_slot = pend_slot_reg[2];
        end
    end

    always_comb
    begin
        if (take)
        begin
            pend_valid_next = new_mask;
        end
        else if (pop)
        begin
            pend_valid_next = pend_valid_reg & ~pop_mask;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
    end

    // slot valid bits and the request toward the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 3'b000;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (res_ready)
            begin
                res_valid_reg <= (pend_valid_reg != 3'b000);
            end
        end
    end

    // slot and request payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_slot_reg[0] <= slot_a;
            pend_slot_reg[1] <= slot_b;
            pend_slot_reg[2] <= slot_c;
        end
        if (res_ready)
        begin
            res_data_reg <= pop_slot;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

[rtl/hgna_divide.sv]
// ----------------------------------------------------------------------------
// hgna_divide: neighbor mean and output register
// Divides each sum by its neighbor count (shift for two and four, reciprocal
// multiply for three) and holds the packed result for the stream.
// ----------------------------------------------------------------------------
module hgna_divide import hgna_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  result_t          res_data,
    output logic             res_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    logic              out_valid_reg;
    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_col_reg;
    logic [TEMP_W-1:0] out_avg_reg;
    logic              out_done_reg;
    logic              advance;
    logic [PROD_W-1:0] prod;
    logic [TEMP_W-1:0] avg;

    // output register frees up when its request is taken
    assign advance   = !out_valid_reg || m_tready;
    assign res_ready = advance;

    // truncated mean
    assign prod = PROD_W'(res_data.sum) * PROD_W'(DIV3_MULT);

    always_comb
    begin
        case (res_data.div)
            DIV_BY2: avg = res_data.sum[TEMP_W:1];
            DIV_BY3: avg = prod[DIV3_SHIFT +: TEMP_W];
            DIV_BY4: avg = res_data.sum[TEMP_W+1:2];
            default: avg = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_row_reg  <= res_data.row;
            out_col_reg  <= res_data.col;
            out_avg_reg  <= avg;
            out_done_reg <= res_data.done;
        end
    end

    // stream side
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - OUT_FIELDS_W)'(0), out_avg_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_done_reg;

endmodule

[rtl/hgna_checker.sv]
// ----------------------------------------------------------------------------
// hgna_checker: port-level checks for the heat grid stencil
// Follows the column count written on the configuration port, checks the
// result columns against it and checks reset, stall hold and padding bits.
// ----------------------------------------------------------------------------
module hgna_checker import hgna_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_wr_en,
    input logic [0:0]        cfg_index,
    input logic [CFG_W-1:0]  cfg_data,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              m_tlast
);

    logic [CFG_W-1:0]  cols_seen_reg;
    logic [SIZE_W-1:0] cols_lim;
    logic [SIZE_W-1:0] out_col;

    // column count as last written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_seen_reg <= CFG_W'(GRID_RESET);
        end
        else if (cfg_wr_en && (cfg_index == REG_GRID_COLS))
        begin
            cols_seen_reg <= cfg_data;
        end
    end

    assign cols_lim = clamp_size(cols_seen_reg, SIZE_W'(MAX_COLS));
    assign out_col  = SIZE_W'(m_tdata[2*POS_W-1:POS_W]);

    // no result and an open input right after reset
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid && s_tready)
        else $error("result shown or input held right after reset");

    // a held result keeps its contents
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // column stays inside the grid
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_col < cols_lim)
        else $error("result column outside the grid");

    // sweep end lands on the last column
    a_done_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> out_col == (cols_lim - SIZE_W'(1)))
        else $error("sweep end not on the last column");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_W-1:OUT_FIELDS_W] == '0))
        else $error("result padding bits set");

endmodule

bind heat_grid_neighbor_average hgna_checker u_hgna_checker (.*);
